[hdl/arpc_pkg.sv]
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants of the ARP cache and responder.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam logic [10:0] ARP_MIN_LEN = 11'd28;
    localparam logic [15:0] OP_REQ      = 16'd1;
    localparam logic [15:0] OP_REP      = 16'd2;
    localparam logic [15:0] HW_ETH      = 16'd1;
    localparam logic [15:0] PROTO_IP    = 16'h0800;
    localparam logic [1:0]  SEND_REQ    = 2'd1;
    localparam logic [1:0]  SEND_REP    = 2'd2;

    localparam logic [3:0] ST_REPLY_SENT  = 4'd0;
    localparam logic [3:0] ST_REQ_NOT_MINE = 4'd1;
    localparam logic [3:0] ST_UPDATED     = 4'd2;
    localparam logic [3:0] ST_LEARN_EXP   = 4'd3;
    localparam logic [3:0] ST_LEARN_UNEXP = 4'd4;
    localparam logic [3:0] ST_REP_NOT_MINE = 4'd5;
    localparam logic [3:0] ST_BAD_OP      = 4'd6;
    localparam logic [3:0] ST_SHORT       = 4'd7;
    localparam logic [3:0] ST_HIT         = 4'd8;
    localparam logic [3:0] ST_MISS        = 4'd9;
    localparam logic [3:0] ST_NULL_IP     = 4'd10;

    localparam logic [0:0] REG_MY_IP  = 1'd0;
    localparam logic [0:0] REG_MY_MAC = 1'd1;

    // scan kinds
    typedef enum logic [1:0] {
        K_LOOKUP,
        K_LEARN_REQ,
        K_LEARN_REP
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_WAIT,
        S_WRITE,
        S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item
        logic scan_rst;  // clear scan index
        logic rd;        // issue table read
        logic step;      // evaluate read data
        logic write;     // write table (learn items), finish
        logic finish;    // finish without write
        logic out_take;  // output taken
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_scan; // decoded item requires scan
        logic done;      // scan resolved
    } t_stat;

endpackage

[hdl/arpc_ram.sv]
// ----------------------------------------------------------------------------
// arpc_ram
// Generic single-port write, single read RAM with registered read.
// ----------------------------------------------------------------------------
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/arpc_ctrl.sv]
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer: decode, table scan with registered reads, write-back, output.
// ----------------------------------------------------------------------------
module arpc_ctrl
    import arpc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_fire,
    input  logic  i_out_fire,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_ready,
    output logic  o_out_valid
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_fire) n_state = S_DECODE;
            S_DECODE: n_state = i_stat.need_scan ? S_SCAN : S_OUT;
            S_SCAN:   n_state = S_WAIT;
            S_WAIT:   n_state = i_stat.done ? S_WRITE : S_SCAN;
            S_WRITE:  n_state = S_OUT;
            S_OUT:    if (i_out_fire) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        o_out_valid    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_fire;
            end
            S_DECODE: begin
                o_cmd.scan_rst = 1'b1;
                o_cmd.finish   = !i_stat.need_scan;
            end
            S_SCAN:  o_cmd.rd = 1'b1;
            S_WAIT:  o_cmd.step = 1'b1;
            S_WRITE: o_cmd.write = 1'b1;
            S_OUT: begin
                o_out_valid  = 1'b1;
                o_cmd.out_take = i_out_fire;
            end
            default: ;
        endcase
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_fire) |=> o_out_valid) else $error("result dropped");
    a_load_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_fire |=> r_state == S_DECODE) else $error("accept not decoded");
endmodule

[hdl/arpc_dp.sv]
// ----------------------------------------------------------------------------
// arpc_dp
// Datapath: input capture, decode, table, scan compare and result register.
// ----------------------------------------------------------------------------
module arpc_dp
    import arpc_pkg::*;
#(
    parameter int ENTRY_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [31:0] i_my_ip,
    input  logic [47:0] i_my_mac,
    input  logic        i_mode,
    input  logic [10:0] i_payload_len,
    input  logic [15:0] i_op_code,
    input  logic [15:0] i_hw_type,
    input  logic [15:0] i_proto_type,
    input  logic [47:0] i_sender_mac,
    input  logic [31:0] i_sender_ip,
    input  logic [31:0] i_target_ip,
    output logic [3:0]  o_status,
    output logic        o_send_valid,
    output logic [1:0]  o_send_op,
    output logic [47:0] o_send_dest_mac,
    output logic [47:0] o_send_target_mac,
    output logic [31:0] o_send_target_ip,
    output logic [47:0] o_found_mac,
    output logic        o_wake_waiter
);
    localparam int AW = $clog2(ENTRY_COUNT);
    localparam logic [AW-1:0] LAST = AW'(ENTRY_COUNT - 1);

    logic        r_mode;
    logic [10:0] r_len;
    logic [15:0] r_op, r_hw, r_pro;
    logic [47:0] r_smac;
    logic [31:0] r_sip, r_tip;
    t_kind       r_kind;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_hit_idx;
    logic        r_hit;
    logic [31:0] r_exp_ip;
    logic        r_waiter;
    logic [ENTRY_COUNT-1:0] r_vld;

    logic [3:0]  r_status;
    logic        r_send_valid;
    logic [1:0]  r_send_op;
    logic [47:0] r_dest, r_tmac, r_fmac;
    logic [31:0] r_tgt;
    logic        r_wake;

    logic [31:0] w_ip_rd, w_ip;
    logic [47:0] w_mac_rd, w_mac;
    logic        w_vld;
    logic        w_we;
    logic        w_stop;

    assign w_we = i_cmd.write && (r_kind != K_LOOKUP);

    arpc_ram #(.WIDTH(32), .DEPTH(ENTRY_COUNT)) u_ip_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_hit_idx), .i_wdata(r_sip),
        .i_raddr(r_idx), .o_rdata(w_ip_rd));
    arpc_ram #(.WIDTH(48), .DEPTH(ENTRY_COUNT)) u_mac_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_hit_idx), .i_wdata(r_smac),
        .i_raddr(r_idx), .o_rdata(w_mac_rd));

    assign w_vld = r_vld[r_idx];
    assign w_ip  = w_vld ? w_ip_rd : 32'd0;
    assign w_mac = w_vld ? w_mac_rd : 48'd0;

    // scan stops at the current slot
    always_comb begin
        w_stop = (r_idx == LAST);
        case (r_kind)
            K_LOOKUP:    if (w_ip == r_tip) w_stop = 1'b1;
            K_LEARN_REQ: if (w_ip == r_sip || w_ip == 32'd0) w_stop = 1'b1;
            K_LEARN_REP: if (w_ip == 32'd0 || w_ip == r_sip) w_stop = 1'b1;
            default: ;
        endcase
    end

    // decode of captured item
    logic [3:0] w_dstat;
    logic       w_need;
    t_kind      w_kind;
    always_comb begin
        w_need  = 1'b0;
        w_kind  = K_LOOKUP;
        w_dstat = ST_BAD_OP;
        if (r_mode) begin
            w_kind = K_LOOKUP;
            if (r_tip == 32'd0) w_dstat = ST_NULL_IP;
            else w_need = 1'b1;
        end else if (r_len < ARP_MIN_LEN) begin
            w_dstat = ST_SHORT;
        end else if (r_op == OP_REQ) begin
            w_kind = K_LEARN_REQ;
            if (r_hw != HW_ETH || r_pro != PROTO_IP || r_tip != i_my_ip)
                w_dstat = ST_REQ_NOT_MINE;
            else w_need = 1'b1;
        end else if (r_op == OP_REP) begin
            w_kind = K_LEARN_REP;
            if (r_tip != i_my_ip) w_dstat = ST_REP_NOT_MINE;
            else w_need = 1'b1;
        end
    end

    assign o_stat.need_scan = w_need;
    assign o_stat.done      = w_stop;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode; r_len <= i_payload_len; r_op <= i_op_code;
            r_hw <= i_hw_type; r_pro <= i_proto_type; r_smac <= i_sender_mac;
            r_sip <= i_sender_ip; r_tip <= i_target_ip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0; r_hit <= 1'b0;
            r_hit_idx <= '0; r_exp_ip <= '0; r_waiter <= 1'b0; r_vld <= '0;
            r_kind <= K_LOOKUP;
        end else begin
            if (i_cmd.scan_rst) begin
                r_kind <= w_kind;
                r_idx <= '0; r_hit <= 1'b0;
            end
            if (i_cmd.step) begin
                case (r_kind)
                    K_LOOKUP: begin
                        if (w_ip == r_tip) r_hit <= 1'b1;
                    end
                    K_LEARN_REQ: begin
                        if (w_stop) r_hit_idx <= r_idx;
                    end
                    K_LEARN_REP: begin
                        if (w_ip == 32'd0) begin
                            r_hit_idx <= r_idx; r_hit <= 1'b0;
                        end else if (w_ip == r_sip) begin
                            r_hit_idx <= r_idx; r_hit <= 1'b1;
                        end else if (r_idx == LAST) begin
                            r_hit_idx <= r_idx; r_hit <= 1'b0;
                        end
                    end
                    default: ;
                endcase
                if (!w_stop) r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.write) begin
                case (r_kind)
                    K_LOOKUP: if (!r_hit) begin
                        r_exp_ip <= r_tip; r_waiter <= 1'b1;
                    end
                    K_LEARN_REP: r_waiter <= 1'b0;
                    default: ;
                endcase
            end
            if (w_we) r_vld[r_hit_idx] <= 1'b1;
        end
    end

    // result register; hit mac is read data still held at the hit index
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status <= w_dstat; r_send_valid <= 1'b0; r_send_op <= '0;
            r_dest <= '0; r_tmac <= '0; r_tgt <= '0; r_fmac <= '0; r_wake <= 1'b0;
        end
        if (i_cmd.write) begin
            r_send_valid <= 1'b0; r_send_op <= '0; r_dest <= '0; r_tmac <= '0;
            r_tgt <= '0; r_fmac <= '0; r_wake <= 1'b0;
            case (r_kind)
                K_LOOKUP: begin
                    if (r_hit) begin
                        r_status <= ST_HIT; r_fmac <= w_mac;
                    end else begin
                        r_status <= ST_MISS; r_send_valid <= 1'b1; r_send_op <= SEND_REQ;
                        r_dest <= '1; r_tgt <= r_tip;
                    end
                end
                K_LEARN_REQ: begin
                    r_status <= ST_REPLY_SENT; r_send_valid <= 1'b1;
                    r_send_op <= SEND_REP; r_dest <= r_smac; r_tmac <= r_smac;
                    r_tgt <= r_sip;
                end
                default: begin
                    r_wake <= r_waiter;
                    if (r_hit) r_status <= ST_UPDATED;
                    else r_status <= (r_exp_ip != r_sip) ? ST_LEARN_UNEXP : ST_LEARN_EXP;
                end
            endcase
        end
    end

    assign o_status = r_status; assign o_send_valid = r_send_valid;
    assign o_send_op = r_send_op; assign o_send_dest_mac = r_dest;
    assign o_send_target_mac = r_tmac; assign o_send_target_ip = r_tgt;
    assign o_found_mac = r_fmac; assign o_wake_waiter = r_wake;

    logic w_unused;
    assign w_unused = ^i_my_mac ^ i_cmd.out_take;
endmodule

[hdl/arp_responder_cache.sv]
// ----------------------------------------------------------------------------
// arp_responder_cache
// ARP table with request responder and address resolution.
// ----------------------------------------------------------------------------
// Input stream s_axis: one transaction per ARP payload or lookup; tuser holds
// mode. Output stream m_axis: exactly one result per input transaction.
// Configuration: i_cfg_we writes my_ip (index 0) or my_mac (index 1).
// One item is in flight at a time; s_axis_tready is high only while idle.
// An item without a table scan (short, bad op, not mine, null lookup) goes from
// decode to output; otherwise the scan reads slots in order until it stops, at
// the last slot at the latest; each scan step is one registered table RAM read.
// A result is held on m_axis until taken; a stalled receiver holds the block.
// Reset clears the table valid bits, the waiter and the address registers at once.
// ----------------------------------------------------------------------------
module arp_responder_cache
    import arpc_pkg::*;
#(
    parameter int ENTRY_COUNT = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [47:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // payload_len, op_code, hw_type, proto_type, sender_mac, sender_ip, target_ip
    input  logic [175:0] s_axis_tdata,
    // mode
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, send_op, send_dest_mac, send_target_mac, send_target_ip, found_mac
    output logic [183:0] m_axis_tdata,
    // send_valid, wake_waiter
    output logic [1:0]   m_axis_tuser
);
    logic [31:0] r_my_ip;
    logic [47:0] r_my_mac;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_fire, w_out_fire;
    logic [3:0] w_status; logic w_sv, w_wake; logic [1:0] w_sop;
    logic [47:0] w_dmac, w_tmac, w_fmac; logic [31:0] w_tip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_ip <= '0; r_my_mac <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_MY_IP) r_my_ip <= i_cfg_data[31:0];
            if (i_cfg_index == REG_MY_MAC) r_my_mac <= i_cfg_data;
        end
    end

    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign w_out_fire = m_axis_tvalid && m_axis_tready;

    arpc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_in_fire),
        .i_out_fire(w_out_fire), .i_stat(w_stat), .o_cmd(w_cmd),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid));

    arpc_dp #(.ENTRY_COUNT(ENTRY_COUNT)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_my_ip(r_my_ip), .i_my_mac(r_my_mac), .i_mode(s_axis_tuser),
        .i_payload_len(s_axis_tdata[10:0]), .i_op_code(s_axis_tdata[26:11]),
        .i_hw_type(s_axis_tdata[42:27]), .i_proto_type(s_axis_tdata[58:43]),
        .i_sender_mac(s_axis_tdata[106:59]), .i_sender_ip(s_axis_tdata[138:107]),
        .i_target_ip(s_axis_tdata[170:139]),
        .o_status(w_status), .o_send_valid(w_sv), .o_send_op(w_sop),
        .o_send_dest_mac(w_dmac), .o_send_target_mac(w_tmac),
        .o_send_target_ip(w_tip), .o_found_mac(w_fmac), .o_wake_waiter(w_wake));

    assign m_axis_tdata = {2'b00, w_fmac, w_tip, w_tmac, w_dmac, w_sop, w_status};
    assign m_axis_tuser = {w_wake, w_sv};

    logic w_unused_in;
    assign w_unused_in = ^s_axis_tdata[175:171];
endmodule

[sim/arp_responder_cache_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_responder_cache_test
// Self-checking stream test of the ARP cache and responder: received
// payloads and lookups are driven under several flow-control mixes and
// address settings, and every result is compared with a cycle-free
// software copy of the table, the waiter and the expected address.
// ----------------------------------------------------------------------------
module arp_responder_cache_test;
    import arpc_pkg::*;

    localparam int N_ENTRY   = 16;
    localparam int CYC_LIMIT = 600000;
    localparam int SETTLE    = 3 + 2 * N_ENTRY + 8;

    typedef struct {
        bit        mode;
        bit [10:0] plen;
        bit [15:0] op;
        bit [15:0] hw;
        bit [15:0] proto;
        bit [47:0] smac;
        bit [31:0] sip;
        bit [31:0] tip;
    } arp_item_t;

    typedef struct {
        bit [3:0]  status;
        bit        send_valid;
        bit [1:0]  send_op;
        bit [47:0] dest_mac;
        bit [47:0] tgt_mac;
        bit [31:0] tgt_ip;
        bit [47:0] found_mac;
        bit        wake;
    } arp_res_t;

    class arp_table_sb;
        bit [31:0] ip_tab[N_ENTRY];
        bit [47:0] mac_tab[N_ENTRY];
        bit [31:0] want_ip;
        bit        waiting;
        bit [31:0] own_ip;
        bit [47:0] own_mac;
        arp_res_t  pending_q[$];
        int        errors;

        function void set_reg(bit idx, bit [47:0] val);
            if (idx == REG_MY_IP) own_ip = val[31:0];
            else own_mac = val;
        endfunction

        function void report(string what, bit [63:0] got, bit [63:0] exp);
            $display("mismatch %s: got %0h expected %0h", what, got, exp);
            errors++;
        endfunction

        function void note_item(arp_item_t it);
            arp_res_t r;
            int i;
            r = '{default: 0};
            if (it.mode) begin
                if (it.tip == 0) begin
                    r.status = ST_NULL_IP;
                end else begin
                    r.status = ST_MISS;
                    for (i = 0; i < N_ENTRY; i++) begin
                        if (ip_tab[i] == it.tip) begin
                            r.status = ST_HIT;
                            r.found_mac = mac_tab[i];
                            break;
                        end
                    end
                    if (r.status == ST_MISS) begin
                        want_ip = it.tip;
                        waiting = 1;
                        r.send_valid = 1;
                        r.send_op = SEND_REQ;
                        r.dest_mac = '1;
                        r.tgt_ip = it.tip;
                    end
                end
            end else if (it.plen < ARP_MIN_LEN) begin
                r.status = ST_SHORT;
            end else if (it.op == OP_REQ) begin
                if (it.hw != HW_ETH || it.proto != PROTO_IP || it.tip != own_ip) begin
                    r.status = ST_REQ_NOT_MINE;
                end else begin
                    for (i = 0; i < N_ENTRY; i++) begin
                        if (ip_tab[i] == it.sip || i == N_ENTRY - 1 || ip_tab[i] == 0) begin
                            ip_tab[i] = it.sip;
                            mac_tab[i] = it.smac;
                            break;
                        end
                    end
                    r.status = ST_REPLY_SENT;
                    r.send_valid = 1;
                    r.send_op = SEND_REP;
                    r.dest_mac = it.smac;
                    r.tgt_mac = it.smac;
                    r.tgt_ip = it.sip;
                end
            end else if (it.op == OP_REP) begin
                if (it.tip != own_ip) begin
                    r.status = ST_REP_NOT_MINE;
                end else begin
                    i = 0;
                    while (i < N_ENTRY && ip_tab[i] != 0 && ip_tab[i] != it.sip) i++;
                    if (i < N_ENTRY && ip_tab[i] != 0) begin
                        r.status = ST_UPDATED;
                    end else begin
                        if (i >= N_ENTRY) i = N_ENTRY - 1;
                        r.status = (want_ip != it.sip) ? ST_LEARN_UNEXP : ST_LEARN_EXP;
                    end
                    ip_tab[i] = it.sip;
                    mac_tab[i] = it.smac;
                    if (waiting) begin
                        r.wake = 1;
                        waiting = 0;
                    end
                end
            end else begin
                r.status = ST_BAD_OP;
            end
            pending_q.push_back(r);
        endfunction

        function void check_result(arp_res_t g);
            arp_res_t e;
            if (pending_q.size() == 0) begin
                report("unexpected result, status", g.status, 0);
                return;
            end
            e = pending_q.pop_front();
            if (g.status != e.status) report("status", g.status, e.status);
            if (g.send_valid != e.send_valid) report("send_valid", g.send_valid, e.send_valid);
            if (g.send_op != e.send_op) report("send_op", g.send_op, e.send_op);
            if (g.dest_mac != e.dest_mac) report("send_dest_mac", g.dest_mac, e.dest_mac);
            if (g.tgt_mac != e.tgt_mac) report("send_target_mac", g.tgt_mac, e.tgt_mac);
            if (g.tgt_ip != e.tgt_ip) report("send_target_ip", g.tgt_ip, e.tgt_ip);
            if (g.found_mac != e.found_mac) report("found_mac", g.found_mac, e.found_mac);
            if (g.wake != e.wake) report("wake_waiter", g.wake, e.wake);
        endfunction
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_cfg_we = 0;
    logic         i_cfg_index = 0;
    logic [47:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [175:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [183:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    arp_table_sb sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;
    bit [31:0] ip_pool[24];

    arp_responder_cache #(.ENTRY_COUNT(N_ENTRY)) dut (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("** arp_responder_cache: FAILED **");
            $finish;
        end
    end

    // receiver: check each transaction, one long hold-off after 30 results
    initial begin
        arp_res_t g;
        int got;
        bit held;
        got = 0;
        held = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                g.status     = m_axis_tdata[3:0];
                g.send_op    = m_axis_tdata[5:4];
                g.dest_mac   = m_axis_tdata[53:6];
                g.tgt_mac    = m_axis_tdata[101:54];
                g.tgt_ip     = m_axis_tdata[133:102];
                g.found_mac  = m_axis_tdata[181:134];
                g.send_valid = m_axis_tuser[0];
                g.wake       = m_axis_tuser[1];
                sb.check_result(g);
                got++;
                if (got == 30 && !held) begin
                    held = 1;
                    m_axis_tready <= 0;
                    repeat (300) @(posedge i_clk);
                    continue;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(arp_item_t it);
        int gap;
        s_axis_tdata <= {5'd0, it.tip, it.sip, it.smac, it.proto, it.hw, it.op, it.plen};
        s_axis_tuser <= it.mode;
        s_axis_tvalid <= 1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(it);
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(bit idx, bit [47:0] val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_reg(idx, val);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic arp_item_t mk(bit mode, bit [10:0] plen, bit [15:0] op,
                                     bit [31:0] sip, bit [31:0] tip);
        arp_item_t it;
        it.mode = mode;
        it.plen = plen;
        it.op = op;
        it.hw = HW_ETH;
        it.proto = PROTO_IP;
        it.smac = {16'($urandom), $urandom};
        it.sip = sip;
        it.tip = tip;
        return it;
    endfunction

    function automatic arp_item_t rand_item();
        arp_item_t it;
        int pick;
        pick = $urandom_range(99);
        it = mk(1'b0, 11'($urandom_range(28, 64)), OP_REQ,
                ip_pool[$urandom_range(23)], sb.own_ip);
        if (pick < 10) begin
            it.mode = 1'($urandom);
            it.plen = 11'($urandom);
            it.op = 16'($urandom);
            it.hw = 16'($urandom);
            it.proto = 16'($urandom);
            it.sip = $urandom;
            it.tip = $urandom;
        end else if (pick < 45) begin
            it.mode = 1;
            it.tip = ($urandom_range(19) == 0) ? 32'd0 : ip_pool[$urandom_range(23)];
        end else if (pick < 75) begin
            it.op = OP_REP;
            if ($urandom_range(3) == 0) it.sip = sb.want_ip;
            if ($urandom_range(9) == 0) it.tip = $urandom;
        end else begin
            if ($urandom_range(9) == 0) it.hw = 16'($urandom);
            if ($urandom_range(9) == 0) it.proto = 16'($urandom);
            if ($urandom_range(9) == 0) it.tip = $urandom;
            if ($urandom_range(15) == 0) it.plen = 11'($urandom_range(0, 27));
        end
        return it;
    endfunction

    initial begin
        arp_item_t it;
        bit [31:0] ip_a;
        bit [31:0] ip_b;
        int ph;
        int k;
        for (k = 0; k < 24; k++) ip_pool[k] = 32'h0A00_0000 + $urandom_range(1, 4000);
        ip_pool[23] = 32'hFFFF_FFFF;
        ip_a = ip_pool[0];
        ip_b = ip_pool[1] ^ 32'h0100_0000;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        write_reg(REG_MY_IP, 48'h0000_C0A8_0001);
        write_reg(REG_MY_MAC, 48'h0200_0000_0001);

        // directed
        send_item(mk(0, 11'd0, OP_REQ, ip_a, sb.own_ip));
        send_item(mk(0, 11'd27, OP_REP, ip_a, sb.own_ip));
        send_item(mk(0, 11'd2047, 16'd0, ip_a, sb.own_ip));
        send_item(mk(0, 11'd28, 16'hFFFF, ip_a, sb.own_ip));
        it = mk(0, 11'd28, OP_REQ, ip_a, sb.own_ip);
        it.hw = 16'hFFFF;
        send_item(it);
        it = mk(0, 11'd28, OP_REQ, ip_a, sb.own_ip);
        it.proto = 16'h86DD;
        send_item(it);
        send_item(mk(0, 11'd28, OP_REQ, ip_a, 32'hC0A8_0002));
        send_item(mk(0, 11'd28, OP_REQ, ip_a, sb.own_ip));
        send_item(mk(1, 11'd0, 16'd0, 32'd0, ip_a));
        send_item(mk(1, 11'd0, 16'd0, 32'd0, 32'd0));
        send_item(mk(1, 11'd0, 16'd0, 32'd0, ip_b));
        send_item(mk(1, 11'd0, 16'd0, 32'd0, ip_b));
        send_item(mk(0, 11'd28, OP_REP, ip_b, sb.own_ip));
        send_item(mk(0, 11'd28, OP_REP, 32'h0B0B_0B0B, sb.own_ip));
        send_item(mk(0, 11'd28, OP_REP, ip_b, sb.own_ip));
        send_item(mk(0, 11'd28, OP_REP, ip_b, 32'hFFFF_FFFF));
        send_item(mk(0, 11'd28, OP_REP, 32'd0, sb.own_ip));
        send_item(mk(0, 11'd28, OP_REQ, 32'd0, sb.own_ip));
        send_item(mk(1, 11'd0, 16'd0, 32'd0, 32'hFFFF_FFFF));
        for (k = 0; k < 5; k++) send_item(mk(0, 11'd60, OP_REQ, 32'h0C00_0000 + k, sb.own_ip));

        // random phases, address registers changed between them
        for (ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_reg(REG_MY_IP, 48'h0000_FFFF_FFFF);
                    write_reg(REG_MY_MAC, 48'hFFFF_FFFF_FFFF);
                end
                1: begin
                    write_reg(REG_MY_IP, 48'd0);
                    write_reg(REG_MY_MAC, 48'd0);
                end
                default: begin
                    write_reg(REG_MY_IP, {16'd0, ip_pool[$urandom_range(22)]});
                    write_reg(REG_MY_MAC, {16'($urandom), $urandom});
                end
            endcase
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 15 : 47) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 15 : 47) : 0;
            for (k = 0; k < 182; k++) send_item(rand_item());
        end

        drain();
        if (sb.errors == 0) $display("** arp_responder_cache: PASSED **");
        else $display("** arp_responder_cache: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
hdl/arpc_pkg.sv
hdl/arpc_ram.sv
hdl/arpc_ctrl.sv
hdl/arpc_dp.sv
hdl/arp_responder_cache.sv
sim/arp_responder_cache_test.sv
